FILE: hw/rtl/aes_pkg.sv
// Shared types, tables and round functions for the AES-128 ECB/CBC cipher.
// Used by the top level aes128_block_cipher_ecb_cbc and by its checker.
// Depends on nothing else.
`default_nettype none

package aes_pkg;

    localparam int BLOCK_W  = 128;
    localparam int HALF_W   = 64;
    localparam int NUM_ROWS = 11;
    localparam int ROW_W    = $clog2(NUM_ROWS);
    localparam int CFG_IDX_W = 3;

    localparam logic [ROW_W-1:0] LAST_ROUND = ROW_W'(NUM_ROWS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE = 3'd4;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic              first_block;
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
    } aes_in_t;

    typedef struct packed {
        logic [HALF_W-1:0] result_high;
        logic [HALF_W-1:0] result_low;
    } aes_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_INIT,
        ST_ROUND,
        ST_FINISH
    } aes_state_t;

    typedef logic [7:0] sbox_arr_t [256];

    localparam sbox_arr_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // The inverse table is derived from the forward one at elaboration.
    function automatic sbox_arr_t build_inv_sbox();
        sbox_arr_t t;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam sbox_arr_t INV_SBOX = build_inv_sbox();

    function automatic logic [7:0] rcon(input logic [ROW_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x2, x4, x8;
        for (int k = 0; k < 4; k++) begin
            a[k]  = c[31-8*k -: 8];
            x2    = xtime(a[k]);
            x4    = xtime(x2);
            x8    = xtime(x4);
            m9[k] = x8 ^ a[k];
            mb[k] = x8 ^ x2 ^ a[k];
            md[k] = x8 ^ x4 ^ a[k];
            me[k] = x8 ^ x4 ^ x2;
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] s,
                                                     input logic [BLOCK_W-1:0] rk,
                                                     input logic last);
        logic [BLOCK_W-1:0] t;
        logic [BLOCK_W-1:0] m;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[BLOCK_W-1-32*c -: 32] = last ? t[BLOCK_W-1-32*c -: 32]
                                           : mix_col(t[BLOCK_W-1-32*c -: 32]);
        end
        return m ^ rk;
    endfunction

    function automatic logic [BLOCK_W-1:0] dec_round(input logic [BLOCK_W-1:0] s,
                                                     input logic [BLOCK_W-1:0] rk,
                                                     input logic last);
        logic [BLOCK_W-1:0] t;
        logic [BLOCK_W-1:0] m;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(4*c+r) -: 8] = INV_SBOX[get_byte(s, 4*((c-r+4)%4)+r)];
            end
        end
        t = t ^ rk;
        for (int c = 0; c < 4; c++) begin
            m[BLOCK_W-1-32*c -: 32] = last ? t[BLOCK_W-1-32*c -: 32]
                                           : inv_mix_col(t[BLOCK_W-1-32*c -: 32]);
        end
        return m;
    endfunction

    // One full AES-128 key schedule step: four words from the previous four.
    function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] w,
                                                          input logic [7:0] rc);
        logic [31:0] t, n0, n1, n2, n3;
        t  = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
        n0 = w[127:96] ^ t;
        n1 = w[95:64] ^ n0;
        n2 = w[63:32] ^ n1;
        n3 = w[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/aes128_block_cipher_ecb_cbc.sv
// An accepted input beat passes ST_INIT, then ST_ROUND for ten rounds, then ST_FINISH,
// which registers the result beat; no new block is taken until the block is idle again.
// The single round unit is fed one 128-bit round key per cycle from an 11-row key memory.
// A key write expands the schedule into all 11 rows, one round key row per cycle.
// Reset (rst_n, asynchronous, active low) clears control, key, IV, mode and chain value;
// the round key memory is undefined until a key is written.
`default_nettype none

module aes128_block_cipher_ecb_cbc (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire aes_pkg::aes_in_t            in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output aes_pkg::aes_out_t                out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [aes_pkg::HALF_W-1:0]  cfg_data
);
    import aes_pkg::*;

    aes_state_t             state_reg, state_next;
    logic [ROW_W-1:0]       cnt_reg, cnt_next;
    logic [HALF_W-1:0]      key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic                   chain_mode_reg;
    logic [BLOCK_W-1:0]     chain_reg;
    logic [BLOCK_W-1:0]     kw_reg;
    logic [BLOCK_W-1:0]     s_reg;
    logic [BLOCK_W-1:0]     blk_reg;
    logic                   dec_reg;
    logic [BLOCK_W-1:0]     rk_reg;
    logic [BLOCK_W-1:0]     rk_mem [NUM_ROWS];
    logic [ROW_W-1:0]       rd_addr;
    logic [ROW_W-1:0]       cnt_inc;
    logic                   out_valid_reg;
    aes_out_t               out_reg;

    logic                   in_fire, cfg_fire, key_write, out_fire, finish_go;
    logic [BLOCK_W-1:0]     in_block, chain_sel, round_out, result;

    assign in_fire   = in_valid && !in_stall;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign key_write = cfg_fire && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);
    assign out_fire  = out_valid_reg && !out_stall;
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign in_block  = {in_data.block_high, in_data.block_low};
    assign chain_sel = in_data.first_block ? {iv_high_reg, iv_low_reg} : chain_reg;
    assign cnt_inc   = cnt_reg + ROW_W'(1);
    assign round_out = dec_reg ? dec_round(s_reg, rk_reg, cnt_reg == LAST_ROUND)
                               : enc_round(s_reg, rk_reg, cnt_reg == LAST_ROUND);
    assign result    = (chain_mode_reg && dec_reg) ? (s_reg ^ chain_reg) : s_reg;

    // Round key row needed by the next cycle's step.
    always_comb
    begin
        if (state_reg == ST_IDLE) begin
            rd_addr = (in_data.opcode == OP_DECRYPT) ? LAST_ROUND : '0;
        end else begin
            rd_addr = dec_reg ? (LAST_ROUND - cnt_inc) : cnt_inc;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (key_write) begin
                    state_next = ST_EXPAND;
                    cnt_next   = '0;
                end else if (in_fire) begin
                    state_next = ST_INIT;
                    cnt_next   = '0;
                end
            end
            ST_EXPAND: begin
                cnt_next = cnt_inc;
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_IDLE;
                end
            end
            ST_INIT: begin
                state_next = ST_ROUND;
                cnt_next   = cnt_inc;
            end
            ST_ROUND: begin
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            ST_FINISH: begin
                if (finish_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            iv_high_reg    <= '0;
            iv_low_reg     <= '0;
            chain_mode_reg <= 1'b0;
            chain_reg      <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_fire) begin
                unique case (cfg_index)
                    CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                    CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                    CFG_IV_HIGH:    iv_high_reg    <= cfg_data;
                    CFG_IV_LOW:     iv_low_reg     <= cfg_data;
                    CFG_CHAIN_MODE: chain_mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                chain_reg <= chain_sel;
            end else if (finish_go && chain_mode_reg) begin
                chain_reg <= dec_reg ? blk_reg : s_reg;
            end
            if (finish_go) begin
                out_valid_reg <= 1'b1;
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        rk_reg <= rk_mem[rd_addr];
        if (state_reg == ST_EXPAND) begin
            rk_mem[cnt_reg] <= kw_reg;
        end
        if (key_write) begin
            kw_reg <= (cfg_index == CFG_KEY_HIGH) ? {cfg_data, key_low_reg}
                                                  : {key_high_reg, cfg_data};
        end else if (state_reg == ST_EXPAND) begin
            kw_reg <= next_round_key(kw_reg, rcon(cnt_reg));
        end
        if (in_fire) begin
            dec_reg <= in_data.opcode;
            blk_reg <= in_block;
            s_reg   <= (chain_mode_reg && in_data.opcode == OP_ENCRYPT)
                       ? (in_block ^ chain_sel) : in_block;
        end else if (state_reg == ST_INIT) begin
            s_reg <= s_reg ^ rk_reg;
        end else if (state_reg == ST_ROUND) begin
            s_reg <= round_out;
        end
        if (finish_go) begin
            out_reg <= {result[BLOCK_W-1 -: HALF_W], result[HALF_W-1:0]};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/aes_checker.sv
// Port-level checker for aes128_block_cipher_ecb_cbc, attached by bind.
// Depends on aes_pkg for the payload types and register indexes.
`default_nettype none

module aes_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire aes_pkg::aes_in_t              in_data,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire aes_pkg::aes_out_t             out_data,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [aes_pkg::HALF_W-1:0]    cfg_data
);
    import aes_pkg::*;

    // An accepted beat keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // No result can appear right after an item enters.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result beat too early");

    // A key write starts the schedule expansion, which blocks both channels.
    a_key_expand_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW))
        |=> (!cfg_ready && in_stall))
        else $error("block not busy during key expansion");

    // A stalled result beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result beat dropped or changed");

endmodule

bind aes128_block_cipher_ecb_cbc aes_checker u_aes_checker (.*);

`default_nettype wire
